>>> design/fir_cz_pkg.sv
// shared types and codes of the fir filter block
`timescale 1ns / 1ps
`default_nettype none

package fir_cz_pkg;

  // item command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_MODE = 1'd1;

  // commands from controller to datapath
  typedef struct packed {
    logic load_tap;
    logic take_sample;
    logic mac_start;
    logic mac_issue;
    logic load_out;
    logic flush_step;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic emit_ok;
    logic k_last;
    logic mac_empty;
    logic out_free;
    logic more_flush;
  } sts_t;

endpackage

`default_nettype wire

>>> design/fir_cz_channels.sv
// valid/ready channel interfaces of the fir filter block
`timescale 1ns / 1ps
`default_nettype none

interface fir_cz_in_if #(
  parameter int SW = 16,
  parameter int CW = 16,
  parameter int IW = 6
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [IW-1:0]        tap_index;
  logic signed [CW-1:0] tap_value;
  logic signed [SW-1:0] sample;
  logic                 last;

  modport source (output valid, cmd, tap_index, tap_value, sample, last, input ready);
  modport sink   (input valid, cmd, tap_index, tap_value, sample, last, output ready);
endinterface

interface fir_cz_out_if #(
  parameter int SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] filtered;
  logic                 clipped;
  logic                 end_of_signal;

  modport source (output valid, filtered, clipped, end_of_signal, input ready);
  modport sink   (input valid, filtered, clipped, end_of_signal, output ready);
endinterface

interface fir_cz_cfg_if #(
  parameter int DW = 7
);
  logic                               valid;
  logic                               ready;
  logic [fir_cz_pkg::CFG_IDX_W-1:0]   addr;
  logic [DW-1:0]                      data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

>>> design/fir_cz_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fir_cz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/fir_cz_ctrl.sv
// sequencing controller: sample intake, mac pass, output hand-off, zero flush
`timescale 1ns / 1ps
`default_nettype none

module fir_cz_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_cmd_i,
  output logic                   in_ready_o,
  input  wire fir_cz_pkg::sts_t  sts_i,
  output fir_cz_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_ADVANCE
  } state_e;

  state_e state_q, state_d;

  // ready only between items
  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == fir_cz_pkg::CMD_SAMPLE) begin
            cmd_o.take_sample = 1'b1;
            state_d           = ST_DECIDE;
          end else begin
            cmd_o.load_tap = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        if (sts_i.emit_ok) begin
          cmd_o.mac_start = 1'b1;
          state_d         = ST_MAC;
        end else begin
          state_d = ST_ADVANCE;
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (sts_i.k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.mac_empty) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (sts_i.more_flush) begin
          cmd_o.flush_step = 1'b1;
          state_d          = ST_DECIDE;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/fir_cz_dp.sv
// datapath: config, tap and history rams, mac pipeline, rounding and output register
`timescale 1ns / 1ps
`default_nettype none

module fir_cz_dp #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16,
  localparam int IW          = $clog2(MAX_TAPS),
  localparam int CNT_W       = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fir_cz_pkg::cmd_t                cmd_i,
  output fir_cz_pkg::sts_t                     sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fir_cz_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [CNT_W-1:0]                cfg_data_i,
  input  wire logic [IW-1:0]                   tap_index_i,
  input  wire logic signed [COEF_WIDTH-1:0]    tap_value_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  sample_i,
  input  wire logic                            last_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0]       filtered_o,
  output logic                                 clipped_o,
  output logic                                 end_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COEF_WIDTH;
  localparam int PW    = SW + CW;
  localparam int ACC_W = PW + CNT_W;
  localparam int RS_W  = ACC_W - (CW - 2);
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (CW - 3);
  localparam logic signed [RS_W-1:0] SAT_HI = RS_W'({1'b0, {(SW - 1){1'b1}}});
  localparam logic signed [RS_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [CNT_W-1:0] TAPS_MAX = CNT_W'(MAX_TAPS);
  localparam logic [IW-1:0]    PTR_TOP  = IW'(MAX_TAPS - 1);

  logic [CNT_W-1:0]       tap_count_q;
  logic                   phase_mode_q;
  logic [IW-1:0]          wp_q, wp_d;
  logic [CNT_W-1:0]       len_q, seen_q, j_q, k_q;
  logic                   last_q;
  logic [IW-1:0]          rp_q;
  logic                   v_rd_q, v_mul_q, zero_rd_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                   out_valid_q;
  logic signed [SW-1:0]   filtered_q;
  logic                   clipped_q, end_q;

  logic [CNT_W-1:0]       taps_use, half_taps;
  logic [IW-1:0]          coef_waddr;
  logic                   hist_we;
  logic [SW-1:0]          hist_wdata, hist_rdata;
  logic [CW-1:0]          coef_rdata;
  logic                   clear_sig;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RS_W-1:0] rs;
  logic                   clip_hi, clip_lo;

  // taps in use: zero acts as one, large values clamp to the store depth
  always_comb begin
    if (tap_count_q == '0) begin
      taps_use = CNT_W'(1);
    end else if (tap_count_q > TAPS_MAX) begin
      taps_use = TAPS_MAX;
    end else begin
      taps_use = tap_count_q;
    end
  end
  assign half_taps = taps_use >> 1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q  <= CNT_W'(1);
      phase_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        fir_cz_pkg::CFG_TAP_COUNT:  tap_count_q  <= cfg_data_i;
        fir_cz_pkg::CFG_PHASE_MODE: phase_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // tap index wraps at the store depth
  assign coef_waddr = ({1'b0, tap_index_i} >= (IW + 1)'(MAX_TAPS))
                      ? IW'({1'b0, tap_index_i} - (IW + 1)'(MAX_TAPS)) : tap_index_i;

  // history write: a real sample or a flush zero at the next ring slot
  assign hist_we    = cmd_i.take_sample | cmd_i.flush_step;
  assign hist_wdata = cmd_i.take_sample ? sample_i : '0;
  assign wp_d       = (wp_q == PTR_TOP) ? '0 : wp_q + IW'(1);
  assign clear_sig  = cmd_i.finish & last_q;

  fir_cz_ram #(.WIDTH(CW), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.load_tap),
    .wr_addr_i (coef_waddr),
    .wr_data_i (tap_value_i),
    .rd_en_i   (cmd_i.mac_issue),
    .rd_addr_i (k_q[IW-1:0]),
    .rd_data_o (coef_rdata)
  );

  fir_cz_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk_i     (clk_i),
    .wr_en_i   (hist_we),
    .wr_addr_i (wp_d),
    .wr_data_i (hist_wdata),
    .rd_en_i   (cmd_i.mac_issue),
    .rd_addr_i (rp_q),
    .rd_data_o (hist_rdata)
  );

  // history bookkeeping: ring pointer, fill count, seen count, flush step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      len_q  <= '0;
      seen_q <= '0;
      j_q    <= '0;
      last_q <= 1'b0;
    end else begin
      if (hist_we) begin
        wp_q <= wp_d;
        if (len_q != TAPS_MAX) begin
          len_q <= len_q + CNT_W'(1);
        end
      end
      if (cmd_i.take_sample) begin
        last_q <= last_i;
        j_q    <= '0;
        if (seen_q != '1) begin
          seen_q <= seen_q + CNT_W'(1);
        end
      end
      if (cmd_i.flush_step) begin
        j_q <= j_q + CNT_W'(1);
      end
      if (clear_sig) begin
        len_q  <= '0;
        seen_q <= '0;
      end
    end
  end

  // mac control: tap counter and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      v_rd_q  <= 1'b0;
      v_mul_q <= 1'b0;
    end else begin
      if (cmd_i.mac_start) begin
        k_q <= '0;
      end else if (cmd_i.mac_issue) begin
        k_q <= k_q + CNT_W'(1);
      end
      v_rd_q  <= cmd_i.mac_issue;
      v_mul_q <= v_rd_q;
    end
  end

  // mac data: read pointer walks back from newest, product, accumulate
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_start) begin
      rp_q <= wp_q;
    end else if (cmd_i.mac_issue) begin
      rp_q <= (rp_q == '0) ? PTR_TOP : rp_q - IW'(1);
    end
    zero_rd_q <= (k_q >= len_q);
    if (v_rd_q) begin
      if (zero_rd_q) begin
        prod_q <= '0;
      end else begin
        prod_q <= $signed(hist_rdata) * $signed(coef_rdata);
      end
    end
    if (cmd_i.mac_start) begin
      acc_q <= '0;
    end else if (v_mul_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round half up to q1.15 and saturate
  assign acc_rnd = acc_q + $signed(RND_HALF);
  assign rs      = acc_rnd[ACC_W-1:CW-2];
  assign clip_hi = rs > SAT_HI;
  assign clip_lo = rs < SAT_LO;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      filtered_q <= clip_hi ? SAT_HI[SW-1:0] : (clip_lo ? SAT_LO[SW-1:0] : rs[SW-1:0]);
      clipped_q  <= clip_hi | clip_lo;
      end_q      <= phase_mode_q ? (last_q && (j_q == half_taps)) : last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign clipped_o   = clipped_q;
  assign end_o       = end_q;

  // status to the controller
  always_comb begin
    sts_o            = '0;
    sts_o.emit_ok    = !phase_mode_q ||
                       (({1'b0, seen_q} + {1'b0, j_q}) > {1'b0, half_taps});
    sts_o.k_last     = (k_q == taps_use - CNT_W'(1));
    sts_o.mac_empty  = !v_rd_q && !v_mul_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.more_flush = phase_mode_q && last_q && (j_q != half_taps);
  end

  // a result is only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unread output");

  // the mac never reads past the taps in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_issue |-> (k_q < taps_use))
    else $error("mac read beyond tap count");

  // fill count stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= TAPS_MAX)
    else $error("history fill count overflow");

  // end of a signal leaves an empty history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_sig |=> (len_q == '0 && seen_q == '0))
    else $error("history not cleared after last sample");

  // flush zeros only happen on the last sample in centered mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush_step |-> (phase_mode_q && last_q))
    else $error("zero flush outside a centered last sample");

endmodule

`default_nettype wire

>>> design/fir_filter_causal_or_zero_phase.sv
// Direct-form FIR filter over finite sample streams, causal or zero-phase centered.
// Load items (cmd 0) write one Q2.14 tap and are taken in the idle state. A sample item
// (cmd 1) shifts a Q1.15 sample into the history and, when it gives a result, runs one
// multiply-accumulate per tap over a shared multiplier. A sample item that gives a result
// holds the input through these steps: intake, decide, one read per tap in use from the
// tap and history rams (registered reads), a drain of the read, product and accumulate
// stages, a load of the result register and the advance step. A result that still waits
// in the output register stalls the item until it is taken. In causal mode each sample
// gives one result. In zero-phase mode the first floor(taps/2) results of a signal are
// held back and the last sample flushes them with zeros, giving up to floor(taps/2)+1
// results from that item. The result register lets the next item enter while a result waits.
// Configuration is to be written only while no item is in flight; the block itself does
// not enforce this. Cfg ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_causal_or_zero_phase #(
  parameter int MAX_TAPS     = 64,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  fir_cz_in_if.sink    in_i,
  fir_cz_out_if.source out_o,
  fir_cz_cfg_if.sink   cfg_i
);

  localparam int IW    = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  fir_cz_pkg::cmd_t cmd;
  fir_cz_pkg::sts_t sts;
  logic             in_ready;

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  fir_cz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fir_cz_dp #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_i.valid),
    .cfg_addr_i  (cfg_i.addr),
    .cfg_data_i  (CNT_W'(cfg_i.data)),
    .tap_index_i (IW'(in_i.tap_index)),
    .tap_value_i (in_i.tap_value),
    .sample_i    (in_i.sample),
    .last_i      (in_i.last),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .filtered_o  (out_o.filtered),
    .clipped_o   (out_o.clipped),
    .end_o       (out_o.end_of_signal)
  );

endmodule

`default_nettype wire
